### rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle implication failed");

`endif

### rtl/mme_pkg.sv
// types and constants for the matrix multiply engine
// no dependencies; imported by mme_mac, the top level and the checker
package mme_pkg;

  // geometry
  localparam int MAX_DIM   = 16;
  localparam int IDX_W     = 4;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DIM_W     = 5;

  // arithmetic widths, Q16.16 operands and full precision sum
  localparam int Q_W       = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * Q_W;
  localparam int ACC_W     = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int FIT_LSB   = Q_W + FRAC_BITS - 1;

  localparam logic [Q_W-1:0] SAT_POS = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] SAT_NEG = {1'b1, {(Q_W-1){1'b0}}};

  // action codes
  localparam logic [1:0] ACT_WR_A = 2'd0;
  localparam logic [1:0] ACT_WR_B = 2'd1;
  localparam logic [1:0] ACT_RD   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_A_ROWS = 2'd0;
  localparam logic [1:0] CFG_INNER  = 2'd1;
  localparam logic [1:0] CFG_B_COLS = 2'd2;

  typedef struct packed {
    logic [1:0]            action;
    logic [IDX_W-1:0]      row_index;
    logic [IDX_W-1:0]      column_index;
    logic signed [Q_W-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] product_value;
    logic                  saturated;
    logic                  bad_index;
  } out_item_t;

  // control into the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic op_vld;
  } mac_ctrl_t;

  // status out of the multiply-accumulate unit
  typedef struct packed {
    logic prod_vld;
    logic sat;
  } mac_stat_t;

endpackage

### rtl/mme_ram.sv
// simple dual-port memory, one write and one registered read port
// no dependencies
module mme_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/mme_mac.sv
// shared multiply-accumulate unit with Q16.16 rescale and saturation
// depends on mme_pkg
module mme_mac import mme_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mac_ctrl_t             ctrl,
  input  logic signed [Q_W-1:0] op_a,
  input  logic signed [Q_W-1:0] op_b,
  output mac_stat_t             stat,
  output logic [Q_W-1:0]        result
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic [ACC_W-FIT_LSB-1:0] upper;
  logic                     fits;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.op_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op_vld) begin
      prod_r <= op_a * op_b;
    end
  end

  // accumulate stage
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // rescale by truncation, clamp when the sum leaves the Q16.16 range
  assign upper = acc_r[ACC_W-1:FIT_LSB];
  assign fits  = (&upper) | ~(|upper);

  always_comb begin
    if (fits) begin
      result = acc_r[Q_W+FRAC_BITS-1:FRAC_BITS];
    end else if (acc_r[ACC_W-1]) begin
      result = SAT_NEG;
    end else begin
      result = SAT_POS;
    end
  end

  assign stat.prod_vld = prod_vld_r;
  assign stat.sat      = ~fits;

endmodule

### rtl/matrix_multiply_engine_unit.sv
// top level of the matrix multiply engine: sequencer, stores and output register
// depends on mme_pkg, mme_ram and mme_mac
//
// Usage. The in_ channel carries one item per transfer: write an element of A,
// write an element of B, or read one element of C = A * B. Writes outside the
// configured sizes and the unused action code are dropped with no result.
// Every read returns exactly one result on the out_ channel.
// The cfg_ channel writes the three size registers (A rows, inner length,
// B columns), each clamped to 16; it is always ready. The user must write
// it only while idle; the block does not enforce this. A write leaves in_ready
// high. A read walks the inner index on the shared multiply-accumulate unit,
// one product per cycle paced by the single read port of each store, then
// drains through the store read, product and accumulator registers. A read out of
// range or with zero inner length skips the walk and goes to the drain state.
// in_ready is low until a read's result is loaded, so reads do not overlap.
// A result stays in the output register until out_ready takes it; a read that
// finishes while the register is full waits in the drain state.
// Reset (synchronous, rst_n low) sets all sizes to 1 and empties the pipeline;
// the stores are not cleared and must be written before they are read.
module matrix_multiply_engine_unit import mme_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [DIM_W-1:0] rows_r, inner_r, cols_r;
  logic [DIM_W-1:0] cfg_clamped;
  logic [DIM_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] row_r, col_r;
  logic             bad_r;
  logic             data_vld_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;

  logic             in_xfer;
  logic             row_ok_a, col_ok_a, row_ok_b, col_ok_b, rd_ok;
  logic             wr_a, wr_b, rd_go;
  logic             issue;
  logic             busy;
  logic             out_free;
  logic             load_out;
  logic [ADDR_W-1:0] addr_a, addr_b;
  logic [Q_W-1:0]   a_rd_data, b_rd_data;
  logic [Q_W-1:0]   mac_result;
  mac_ctrl_t        mac_ctrl;
  mac_stat_t        mac_stat;

  // configuration writes, sizes clamped to the store dimension
  assign cfg_ready   = 1'b1;
  assign cfg_clamped = (cfg_data > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= DIM_W'(1);
      inner_r <= DIM_W'(1);
      cols_r  <= DIM_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_A_ROWS: rows_r  <= cfg_clamped;
        CFG_INNER:  inner_r <= cfg_clamped;
        CFG_B_COLS: cols_r  <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // input decode
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid & in_ready;
  assign row_ok_a = DIM_W'(in_data.row_index) < rows_r;
  assign col_ok_a = DIM_W'(in_data.column_index) < inner_r;
  assign row_ok_b = DIM_W'(in_data.row_index) < inner_r;
  assign col_ok_b = DIM_W'(in_data.column_index) < cols_r;
  assign rd_ok    = row_ok_a & col_ok_b;
  assign wr_a     = in_xfer & (in_data.action == ACT_WR_A) & row_ok_a & col_ok_a;
  assign wr_b     = in_xfer & (in_data.action == ACT_WR_B) & row_ok_b & col_ok_b;
  assign rd_go    = in_xfer & (in_data.action == ACT_RD);

  // store addressing: writes use the item, reads walk the inner index
  assign issue  = (state_r == ST_RUN);
  assign addr_a = {row_r, k_r[IDX_W-1:0]};
  assign addr_b = {k_r[IDX_W-1:0], col_r};

  mme_ram #(.DATA_W(Q_W), .ADDR_W(ADDR_W)) u_left (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr ({in_data.row_index, in_data.column_index}),
    .wr_data (in_data.element_value),
    .rd_en   (issue),
    .rd_addr (addr_a),
    .rd_data (a_rd_data)
  );

  mme_ram #(.DATA_W(Q_W), .ADDR_W(ADDR_W)) u_right (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr ({in_data.row_index, in_data.column_index}),
    .wr_data (in_data.element_value),
    .rd_en   (issue),
    .rd_addr (addr_b),
    .rd_data (b_rd_data)
  );

  // shared multiply-accumulate unit
  assign mac_ctrl.clear  = rd_go;
  assign mac_ctrl.op_vld = data_vld_r;

  mme_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .op_a   (a_rd_data),
    .op_b   (b_rd_data),
    .stat   (mac_stat),
    .result (mac_result)
  );

  // sequencer
  assign busy     = data_vld_r | mac_stat.prod_vld;
  assign out_free = ~out_valid_r | out_ready;
  assign load_out = (state_r == ST_DRAIN) & ~busy & out_free;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        if (rd_go) begin
          state_nxt = (rd_ok && inner_r != '0) ? ST_RUN : ST_DRAIN;
        end
      end
      ST_RUN: begin
        k_nxt = k_r + DIM_W'(1);
        if (k_nxt == inner_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      data_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      data_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (rd_go) begin
      row_r <= in_data.row_index;
      col_r <= in_data.column_index;
      bad_r <= ~rd_ok;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.product_value <= bad_r ? '0 : mac_result;
      out_data_r.saturated     <= ~bad_r & mac_stat.sat;
      out_data_r.bad_index     <= bad_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/mme_checker.sv
// port-level checker for the matrix multiply engine, bound to the top level
// depends on mme_pkg and assert_macros.svh
`include "assert_macros.svh"

module mme_port_props import mme_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input in_item_t   in_data,
  input logic       out_valid,
  input logic       out_ready,
  input out_item_t  out_data
);

  logic rd_xfer;
  logic out_stall;

  assign rd_xfer   = in_valid & in_ready & (in_data.action == ACT_RD);
  assign out_stall = out_valid & ~out_ready;

  // an out-of-range read returns zero and never a clamp
  `ASSERT_IMPLY(a_bad_is_zero, clk, rst_n, out_valid && out_data.bad_index,
    out_data.product_value == '0 && !out_data.saturated)

  // a clamped result sits on one of the two rails
  `ASSERT_IMPLY(a_sat_rail, clk, rst_n, out_valid && out_data.saturated,
    out_data.product_value == SAT_POS || out_data.product_value == SAT_NEG)

  // a read transfer holds off the next item
  `ASSERT_NEXT(a_read_blocks, clk, rst_n, rd_xfer, !in_ready)

  // a stalled result keeps its valid
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid)

endmodule

bind matrix_multiply_engine_unit mme_port_props u_mme_port_props (.*);
